@@ rtl/display_write_frame_scheduler_assert.svh @@
// Assertion macros used by the display write frame scheduler core module.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef DISPLAY_WRITE_FRAME_SCHEDULER_ASSERT_SVH
`define DISPLAY_WRITE_FRAME_SCHEDULER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define DWFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define DWFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define DWFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dwfs_pkg.sv @@
// Package for the display write frame scheduler: event and result codes,
// the result record, the core-to-queue push bundle and fixed field widths.
package dwfs_pkg;

  localparam int GEN_PORT_W = 16;
  localparam int LINE_W     = 12;
  localparam int CNT_W      = 3;
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = 2;
  localparam int RES_CNT_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX        = 3'd7;
  localparam logic [CNT_W-1:0] BLOCKS_PER_GEN = 3'd2;

  localparam logic [LINE_W-1:0] FRONT_ROWS_RST = 12'd180;
  localparam logic [LINE_W-1:0] PANEL_ROWS_RST = 12'd360;

  localparam logic CFG_FRONT_ROWS = 1'b0;
  localparam logic CFG_PANEL_ROWS = 1'b1;

  typedef enum logic [1:0] {
    EVT_HALF_SCAN   = 2'd0,
    EVT_FRAME_START = 2'd1,
    EVT_RENDER_DONE = 2'd2,
    EVT_WRITE_DONE  = 2'd3
  } evt_mode_t;

  typedef enum logic [1:0] {
    RES_RENDER   = 2'd0,
    RES_WRITE    = 2'd1,
    RES_COMPLETE = 2'd2
  } res_kind_t;

  typedef struct packed {
    res_kind_t              kind;
    logic [GEN_PORT_W-1:0]  gen;
    logic [LINE_W-1:0]      start;
    logic [LINE_W-1:0]      count;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } res_push_t;

endpackage

@@ rtl/dwfs_core.sv @@
// Scheduler core: generation, render, lock, pending and slot state, updated
// once per event. Depends on dwfs_pkg and the assertion macros in the header.
`include "display_write_frame_scheduler_assert.svh"

module dwfs_core #(
  parameter int GEN_SLOTS       = 4,
  parameter int INFLIGHT_BUDGET = 1,
  parameter int GEN_W           = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [1:0]                    evt_mode,
  input  logic [GEN_W-1:0]              evt_gen,
  input  logic                          queue_accepts,
  input  logic [dwfs_pkg::LINE_W-1:0]   front_rows,
  input  logic [dwfs_pkg::LINE_W-1:0]   panel_rows,
  output dwfs_pkg::res_push_t           push
);

  localparam int SIW = $clog2(GEN_SLOTS);
  localparam int PTW = $clog2(GEN_SLOTS + 1);
  localparam int IFW = $clog2(INFLIGHT_BUDGET + 1);
  localparam int CW  = dwfs_pkg::CNT_W;
  localparam int LW  = dwfs_pkg::LINE_W;

  logic [GEN_W-1:0] gen_ctr_r, gen_ctr_nxt;
  logic             rend_vld_r, rend_vld_nxt;
  logic [GEN_W-1:0] rend_gen_r, rend_gen_nxt;
  logic             rdy_vld_r, rdy_vld_nxt;
  logic [GEN_W-1:0] rdy_gen_r, rdy_gen_nxt;
  logic             lock_vld_r, lock_vld_nxt;
  logic [GEN_W-1:0] lock_gen_r, lock_gen_nxt;
  logic [PTW-1:0]   pend_total_r, pend_total_nxt;
  logic [GEN_W-1:0] pend_list_r [GEN_SLOTS];
  logic [GEN_W-1:0] pend_list_nxt [GEN_SLOTS];
  logic             slot_used_r [GEN_SLOTS];
  logic             slot_used_nxt [GEN_SLOTS];
  logic [GEN_W-1:0] slot_gen_r [GEN_SLOTS];
  logic [GEN_W-1:0] slot_gen_nxt [GEN_SLOTS];
  logic [CW-1:0]    slot_sub_r [GEN_SLOTS];
  logic [CW-1:0]    slot_sub_nxt [GEN_SLOTS];
  logic [CW-1:0]    slot_out_r [GEN_SLOTS];
  logic [CW-1:0]    slot_out_nxt [GEN_SLOTS];
  logic [IFW-1:0]   infl_r, infl_nxt;

  dwfs_pkg::evt_mode_t mode;
  logic             scan_evt;
  logic             lock_take;
  logic             wr_lock_vld;
  logic [GEN_W-1:0] wr_gen;
  logic [GEN_W-1:0] chk_gen;
  logic             pend_any;
  logic [SIW-1:0]   pend_idx;
  logic             hit_any;
  logic [SIW-1:0]   hit_idx;
  logic             free_any;
  logic [SIW-1:0]   free_idx;
  logic [SIW-1:0]   sidx;
  logic [PTW-1:0]   pend_last;
  logic [LW-1:0]    blk_start;
  logic [LW-1:0]    blk_len;
  logic             blk_room;
  logic             blk_ok;
  logic             claim;
  logic             write_go;
  logic             render_go;
  logic [CW-1:0]    sub_base;
  logic [CW-1:0]    out_base;
  logic [CW-1:0]    out_dec;
  logic [GEN_W-1:0] gen_inc;
  logic             rdone_fire;
  logic             two_push;
  dwfs_pkg::res_t   res_render;
  dwfs_pkg::res_t   res_write;
  dwfs_pkg::res_t   res_done;

  assign mode        = dwfs_pkg::evt_mode_t'(evt_mode);
  assign scan_evt    = (mode == dwfs_pkg::EVT_HALF_SCAN) ||
                       (mode == dwfs_pkg::EVT_FRAME_START);
  assign lock_take   = (mode == dwfs_pkg::EVT_HALF_SCAN) && rdy_vld_r;
  assign wr_gen      = lock_take ? rdy_gen_r : lock_gen_r;
  assign wr_lock_vld = lock_take || lock_vld_r;
  assign chk_gen     = scan_evt ? wr_gen : evt_gen;
  assign pend_last   = pend_total_r - PTW'(1);
  assign gen_inc     = gen_ctr_r + GEN_W'(1);

  always_comb begin
    pend_any = 1'b0;
    pend_idx = '0;
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = GEN_SLOTS - 1; i >= 0; i--) begin
      if ((PTW'(i) < pend_total_r) && (pend_list_r[i] == chk_gen)) begin
        pend_any = 1'b1;
        pend_idx = SIW'(i);
      end
      if (slot_used_r[i] && (slot_gen_r[i] == chk_gen)) begin
        hit_any = 1'b1;
        hit_idx = SIW'(i);
      end
      if (!slot_used_r[i]) begin
        free_any = 1'b1;
        free_idx = SIW'(i);
      end
    end
  end

  assign sidx = hit_any ? hit_idx : free_idx;

  always_comb begin
    if (mode == dwfs_pkg::EVT_FRAME_START) begin
      blk_start = front_rows;
      blk_len   = panel_rows - front_rows;
      blk_room  = panel_rows > front_rows;
    end else begin
      blk_start = '0;
      blk_len   = front_rows;
      blk_room  = 1'b1;
    end
  end

  assign blk_ok = scan_evt && wr_lock_vld && (infl_r < IFW'(INFLIGHT_BUDGET)) && blk_room &&
                  (blk_len != '0) && pend_any;
  assign claim     = blk_ok && !hit_any && free_any;
  assign write_go  = blk_ok && (hit_any || free_any) && queue_accepts;
  assign render_go = (mode == dwfs_pkg::EVT_HALF_SCAN) && !rend_vld_r &&
                     (pend_total_r <= PTW'(1));

  assign sub_base = claim ? '0 : slot_sub_r[sidx];
  assign out_base = claim ? '0 : slot_out_r[sidx];
  assign out_dec  = (slot_out_r[sidx] != '0) ? slot_out_r[sidx] - CW'(1) : '0;

  always_comb begin
    res_render       = '0;
    res_render.kind  = dwfs_pkg::RES_RENDER;
    res_render.gen   = dwfs_pkg::GEN_PORT_W'(gen_inc);
    res_render.last  = !write_go;
    res_write        = '0;
    res_write.kind   = dwfs_pkg::RES_WRITE;
    res_write.gen    = dwfs_pkg::GEN_PORT_W'(wr_gen);
    res_write.start  = blk_start;
    res_write.count  = blk_len;
    res_write.last   = 1'b1;
    res_done         = '0;
    res_done.kind    = dwfs_pkg::RES_COMPLETE;
    res_done.gen     = dwfs_pkg::GEN_PORT_W'(evt_gen);
    res_done.last    = 1'b1;
  end

  always_comb begin
    gen_ctr_nxt    = gen_ctr_r;
    rend_vld_nxt   = rend_vld_r;
    rend_gen_nxt   = rend_gen_r;
    rdy_vld_nxt    = rdy_vld_r;
    rdy_gen_nxt    = rdy_gen_r;
    lock_vld_nxt   = lock_vld_r;
    lock_gen_nxt   = lock_gen_r;
    pend_total_nxt = pend_total_r;
    pend_list_nxt  = pend_list_r;
    slot_used_nxt  = slot_used_r;
    slot_gen_nxt   = slot_gen_r;
    slot_sub_nxt   = slot_sub_r;
    slot_out_nxt   = slot_out_r;
    infl_nxt       = infl_r;
    push           = '0;
    if (fire) begin
      case (mode)
        dwfs_pkg::EVT_HALF_SCAN, dwfs_pkg::EVT_FRAME_START: begin
          if (lock_take) begin
            lock_gen_nxt = rdy_gen_r;
            lock_vld_nxt = 1'b1;
            rdy_vld_nxt  = 1'b0;
          end
          if (render_go) begin
            gen_ctr_nxt  = gen_inc;
            rend_gen_nxt = gen_inc;
            rend_vld_nxt = 1'b1;
          end
          if (claim) begin
            slot_used_nxt[sidx] = 1'b1;
            slot_gen_nxt[sidx]  = wr_gen;
            slot_sub_nxt[sidx]  = '0;
            slot_out_nxt[sidx]  = '0;
          end
          if (write_go) begin
            infl_nxt           = infl_r + IFW'(1);
            slot_sub_nxt[sidx] = (sub_base == dwfs_pkg::CNT_MAX) ? sub_base :
                                 sub_base + CW'(1);
            slot_out_nxt[sidx] = (out_base == dwfs_pkg::CNT_MAX) ? out_base :
                                 out_base + CW'(1);
          end
          if (render_go) begin
            push.first  = res_render;
            push.second = res_write;
            push.cnt    = write_go ? 2'd2 : 2'd1;
          end else if (write_go) begin
            push.first = res_write;
            push.cnt   = 2'd1;
          end
        end
        dwfs_pkg::EVT_RENDER_DONE: begin
          if (rend_vld_r && (rend_gen_r == evt_gen)) begin
            rend_vld_nxt = 1'b0;
          end
          if (!pend_any && (pend_total_r < PTW'(GEN_SLOTS))) begin
            pend_list_nxt[pend_total_r[SIW-1:0]] = evt_gen;
            pend_total_nxt = pend_total_r + PTW'(1);
          end
          rdy_gen_nxt = evt_gen;
          rdy_vld_nxt = 1'b1;
        end
        dwfs_pkg::EVT_WRITE_DONE: begin
          if (infl_r != '0) begin
            infl_nxt = infl_r - IFW'(1);
          end
          if (hit_any) begin
            slot_out_nxt[sidx] = out_dec;
            if ((slot_sub_r[sidx] >= dwfs_pkg::BLOCKS_PER_GEN) && (out_dec == '0)) begin
              slot_used_nxt[sidx] = 1'b0;
              slot_sub_nxt[sidx]  = '0;
              slot_out_nxt[sidx]  = '0;
              if (pend_any) begin
                pend_list_nxt[pend_idx] = pend_list_r[pend_last[SIW-1:0]];
                pend_total_nxt          = pend_last;
              end
              push.first = res_done;
              push.cnt   = 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_ctr_r    <= '0;
      rend_vld_r   <= 1'b0;
      rend_gen_r   <= '0;
      rdy_vld_r    <= 1'b0;
      rdy_gen_r    <= '0;
      lock_vld_r   <= 1'b0;
      lock_gen_r   <= '0;
      pend_total_r <= '0;
      infl_r       <= '0;
      for (int i = 0; i < GEN_SLOTS; i++) begin
        slot_used_r[i] <= 1'b0;
        slot_sub_r[i]  <= '0;
        slot_out_r[i]  <= '0;
      end
    end else begin
      gen_ctr_r    <= gen_ctr_nxt;
      rend_vld_r   <= rend_vld_nxt;
      rend_gen_r   <= rend_gen_nxt;
      rdy_vld_r    <= rdy_vld_nxt;
      rdy_gen_r    <= rdy_gen_nxt;
      lock_vld_r   <= lock_vld_nxt;
      lock_gen_r   <= lock_gen_nxt;
      pend_total_r <= pend_total_nxt;
      infl_r       <= infl_nxt;
      slot_used_r  <= slot_used_nxt;
      slot_sub_r   <= slot_sub_nxt;
      slot_out_r   <= slot_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_list_r <= pend_list_nxt;
    slot_gen_r  <= slot_gen_nxt;
  end

  assign rdone_fire = fire && (mode == dwfs_pkg::EVT_RENDER_DONE);
  assign two_push   = fire && (push.cnt == 2'd2);

  `DWFS_ASSERT_ALWAYS(a_pend_bound, pend_total_r <= PTW'(GEN_SLOTS), "pending set overflow")
  `DWFS_ASSERT_ALWAYS(a_infl_bound, infl_r <= IFW'(INFLIGHT_BUDGET), "in-flight over budget")
  `DWFS_ASSERT_NEXT(a_rdone_latch, rdone_fire, rdy_vld_r && (pend_total_r != '0), "ready lost")
  `DWFS_ASSERT_IMPL(a_dual_scan, two_push, mode == dwfs_pkg::EVT_HALF_SCAN, "two results off scan")

endmodule

@@ rtl/dwfs_res_fifo.sv @@
// Result queue: takes up to two result records a cycle from the core and
// hands them out one beat at a time. Depends on dwfs_pkg.
module dwfs_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  dwfs_pkg::res_push_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output dwfs_pkg::res_t      head
);

  localparam int PW = dwfs_pkg::RES_PTR_W;
  localparam int CW = dwfs_pkg::RES_CNT_W;

  dwfs_pkg::res_t mem_r [dwfs_pkg::RES_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  wr_ptr_p1;
  logic           pop;

  assign room      = cnt_r <= CW'(dwfs_pkg::RES_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

@@ rtl/display_write_frame_scheduler.sv @@
// Display write frame scheduler top level. An event is held in the input register and
// processed by the core once the result queue has room; its results enter the queue.
// Throughput: one event per cycle while the result queue holds at most two records;
// results leave at one beat per cycle while out_stall is low, so events with two results set the pace.
// Reset is synchronous and active low; it clears all scheduler state and the queue
// and restores the front half to 180 lines and the panel to 360 lines.
module display_write_frame_scheduler #(
  parameter int GEN_SLOTS       = 4,
  parameter int INFLIGHT_BUDGET = 1,
  parameter int GEN_BITS        = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_event_mode,
  input  logic [dwfs_pkg::GEN_PORT_W-1:0]   in_event_gen,
  input  logic                              in_queue_accepts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_result_kind,
  output logic [dwfs_pkg::GEN_PORT_W-1:0]   out_result_gen,
  output logic [dwfs_pkg::LINE_W-1:0]       out_first_row,
  output logic [dwfs_pkg::LINE_W-1:0]       out_line_count,
  output logic                              out_last,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [dwfs_pkg::LINE_W-1:0]       cfg_wdata
);

  localparam int GEN_W = (GEN_BITS < dwfs_pkg::GEN_PORT_W) ? GEN_BITS : dwfs_pkg::GEN_PORT_W;

  logic                            in_vld_r;
  logic [1:0]                      evt_mode_r;
  logic [dwfs_pkg::GEN_PORT_W-1:0] evt_gen_r;
  logic                            qacc_r;
  logic [dwfs_pkg::LINE_W-1:0]     front_rows_r;
  logic [dwfs_pkg::LINE_W-1:0]     panel_rows_r;
  logic                            room;
  logic                            fire;
  logic                            in_take;
  dwfs_pkg::res_push_t             push;
  dwfs_pkg::res_t                  head;

  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      evt_mode_r <= in_event_mode;
      evt_gen_r  <= in_event_gen;
      qacc_r     <= in_queue_accepts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_rows_r <= dwfs_pkg::FRONT_ROWS_RST;
      panel_rows_r <= dwfs_pkg::PANEL_ROWS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dwfs_pkg::CFG_FRONT_ROWS: begin
          front_rows_r <= cfg_wdata;
        end
        dwfs_pkg::CFG_PANEL_ROWS: begin
          panel_rows_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  dwfs_core #(
    .GEN_SLOTS       (GEN_SLOTS),
    .INFLIGHT_BUDGET (INFLIGHT_BUDGET),
    .GEN_W           (GEN_W)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .evt_mode      (evt_mode_r),
    .evt_gen       (evt_gen_r[GEN_W-1:0]),
    .queue_accepts (qacc_r),
    .front_rows    (front_rows_r),
    .panel_rows    (panel_rows_r),
    .push          (push)
  );

  dwfs_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_result_kind = head.kind;
  assign out_result_gen  = head.gen;
  assign out_first_row   = head.start;
  assign out_line_count  = head.count;
  assign out_last        = head.last;

endmodule
